FILE: hw/rtl/rld_pkg.sv
// shared types and constants for the radial lens distortion remap
`default_nettype none
package rld_pkg;

   localparam int ADDR_W  = 5;
   localparam int DATA_W  = 32;
   localparam int PIX_W   = 12;
   localparam int DIM_W   = 13;
   localparam int NORM_W  = 24;
   localparam int COEF_W  = 20;
   localparam int SUMSQ_W = 26;
   localparam int RAD_W   = 42;
   localparam int ROOT_W  = 21;
   localparam int R_W     = 29;
   localparam int T_W     = 35;
   localparam int OUT_W   = 22;

   typedef enum logic [2:0] {
      REG_ENABLE = 3'd0,
      REG_WIDTH  = 3'd1,
      REG_HEIGHT = 3'd2,
      REG_NORM   = 3'd3,
      REG_COEF_A = 3'd4,
      REG_COEF_B = 3'd5,
      REG_COEF_C = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic                     en;
      logic [DIM_W-1:0]         width;
      logic [DIM_W-1:0]         height;
      logic [NORM_W-1:0]        norm;
      logic signed [COEF_W-1:0] a;
      logic signed [COEF_W-1:0] b;
      logic signed [COEF_W-1:0] c;
   } cfg_type;

   // per-item data that rides along with the radius computation
   typedef struct packed {
      logic                    en;
      logic signed [PIX_W:0]   dx;
      logic signed [PIX_W:0]   dy;
      logic [PIX_W-1:0]        cx;
      logic [PIX_W-1:0]        cy;
   } side_type;

endpackage
`default_nettype wire

FILE: hw/rtl/rld_csr.sv
// configuration register file with apb-style access
`default_nettype none
module rld_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [rld_pkg::ADDR_W-1:0] paddr,
   input  logic [rld_pkg::DATA_W-1:0] pwdata,
   output logic [rld_pkg::DATA_W-1:0] prdata,
   output logic                       pready,
   output rld_pkg::cfg_type           cfg
);
   import rld_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type idx;
   logic          wr;

   assign idx    = reg_index_type'(paddr[ADDR_W-1:2]);
   assign wr     = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            REG_ENABLE: cfg_in.en     = pwdata[0];
            REG_WIDTH:  cfg_in.width  = pwdata[DIM_W-1:0];
            REG_HEIGHT: cfg_in.height = pwdata[DIM_W-1:0];
            REG_NORM:   cfg_in.norm   = pwdata[NORM_W-1:0];
            REG_COEF_A: cfg_in.a      = $signed(pwdata[COEF_W-1:0]);
            REG_COEF_B: cfg_in.b      = $signed(pwdata[COEF_W-1:0]);
            REG_COEF_C: cfg_in.c      = $signed(pwdata[COEF_W-1:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_ENABLE: prdata = DATA_W'(cfg_ff.en);
         REG_WIDTH:  prdata = DATA_W'(cfg_ff.width);
         REG_HEIGHT: prdata = DATA_W'(cfg_ff.height);
         REG_NORM:   prdata = DATA_W'(cfg_ff.norm);
         REG_COEF_A: prdata = DATA_W'(unsigned'(cfg_ff.a));
         REG_COEF_B: prdata = DATA_W'(unsigned'(cfg_ff.b));
         REG_COEF_C: prdata = DATA_W'(unsigned'(cfg_ff.c));
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.en     <= 1'b0;
         cfg_ff.width  <= DIM_W'(1);
         cfg_ff.height <= DIM_W'(1);
         cfg_ff.norm   <= '0;
         cfg_ff.a      <= '0;
         cfg_ff.b      <= '0;
         cfg_ff.c      <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/rld_sqrt.sv
// pipelined integer square root, one result bit per stage
`default_nettype none
module rld_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [rld_pkg::RAD_W-1:0]  in_radicand,
   input  rld_pkg::side_type          in_side,
   output logic                       out_valid,
   output logic [rld_pkg::ROOT_W-1:0] out_root,
   output rld_pkg::side_type          out_side
);
   import rld_pkg::*;

   localparam int STAGES = ROOT_W;
   localparam int REM_W  = ROOT_W + 3;

   logic [STAGES-1:0] vld_ff;
   logic [RAD_W-1:0]  rad_ff  [0:STAGES-1];
   logic [REM_W-1:0]  rem_ff  [0:STAGES-1];
   logic [ROOT_W-1:0] root_ff [0:STAGES-1];
   side_type          side_ff [0:STAGES-1];

   for (genvar g = 0; g < STAGES; g++) begin : g_stage
      logic              vld_src;
      logic [RAD_W-1:0]  rad_src;
      logic [REM_W-1:0]  rem_src;
      logic [ROOT_W-1:0] root_src;
      side_type          side_src;
      logic [REM_W-1:0]  rem_sh;
      logic [REM_W-1:0]  trial;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      if (g == 0) begin : g_first
         assign vld_src  = in_valid;
         assign rad_src  = in_radicand;
         assign rem_src  = '0;
         assign root_src = '0;
         assign side_src = in_side;
      end else begin : g_next
         assign vld_src  = vld_ff[g-1];
         assign rad_src  = rad_ff[g-1];
         assign rem_src  = rem_ff[g-1];
         assign root_src = root_ff[g-1];
         assign side_src = side_ff[g-1];
      end

      // bring down the next two radicand bits, try root*4+1
      assign rem_sh = {rem_src[REM_W-3:0], rad_src[RAD_W-1 -: 2]};
      assign trial  = {1'b0, root_src, 2'b01};

      always_comb begin
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_src[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_src[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else begin
            vld_ff[g] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         rad_ff[g]  <= {rad_src[RAD_W-3:0], 2'b00};
         rem_ff[g]  <= rem_in;
         root_ff[g] <= root_in;
         side_ff[g] <= side_src;
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign out_root  = root_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];

endmodule
`default_nettype wire

FILE: hw/rtl/rld_poly.sv
// radius scaling, cubic polynomial and final coordinate stages
`default_nettype none
module rld_poly (
   input  logic                              clock,
   input  logic                              reset,
   input  rld_pkg::cfg_type                  cfg,
   input  logic                              in_valid,
   input  logic [rld_pkg::ROOT_W-1:0]        in_root,
   input  rld_pkg::side_type                 in_side,
   output logic                              out_valid,
   output logic signed [rld_pkg::OUT_W-1:0]  out_x,
   output logic signed [rld_pkg::OUT_W-1:0]  out_y,
   output logic                              out_sat
);
   import rld_pkg::*;

   localparam int P_W   = 50;
   localparam int SUM_W = 65;
   localparam int XY_W  = 48;
   localparam int F_W   = 41;
   localparam int KC_W  = 23;
   localparam logic signed [P_W-1:0] MID_HI = P_W'(64'sd8589934592);
   localparam logic signed [P_W-1:0] MID_LO = -MID_HI;
   localparam logic signed [T_W-1:0] K_ONE  = T_W'(65536);
   localparam logic signed [F_W-1:0] O_HI   = F_W'(2097151);
   localparam logic signed [F_W-1:0] O_LO   = -F_W'(2097152);

   function automatic logic signed [T_W-1:0] clamp_mid(input logic signed [P_W-1:0] v);
      logic signed [T_W-1:0] res;
      if (v > MID_HI) begin
         res = T_W'(MID_HI);
      end else if (v < MID_LO) begin
         res = T_W'(MID_LO);
      end else begin
         res = T_W'(v);
      end
      return res;
   endfunction

   // stage valids and side data
   logic [8:0] vld_ff;
   side_type   side_ff [1:8];

   logic [R_W-1:0] r1_ff, r2_ff, r3_ff, r4_ff, r5_ff;

   // p1: r = |d| * norm
   logic [ROOT_W+NORM_W-1:0] rn;
   assign rn = (ROOT_W+NORM_W)'(in_root) * (ROOT_W+NORM_W)'(cfg.norm);

   // p2: a * r
   logic signed [P_W-1:0] pa_in, pa2_ff;
   assign pa_in = cfg.a * $signed({1'b0, r1_ff});

   // p3: t1 = a*r/2^16 + b
   logic signed [T_W-1:0] t1_in, t1_ff;
   assign t1_in = T_W'(pa2_ff >>> 16) + T_W'(cfg.b);

   // p4 / p6: split multiply by r
   logic signed [P_W:0]   pl_in, pl_ff;
   logic signed [P_W-1:0] ph_in, ph_ff;
   logic signed [T_W-1:0] t2_in, t2_ff;
   logic signed [P_W:0]   ql_in, ql_ff;
   logic signed [P_W-1:0] qh_in, qh_ff;
   logic signed [T_W-1:0] k_in, k_ff;
   assign pl_in = t1_ff * $signed({1'b0, r3_ff[14:0]});
   assign ph_in = t1_ff * $signed({1'b0, r3_ff[R_W-1:15]});

   // p5: t2 = clamp(t1*r/2^16 + c)
   logic signed [SUM_W-1:0] psum;
   assign psum  = (SUM_W'(ph_ff) <<< 15) + SUM_W'(pl_ff);
   assign t2_in = clamp_mid(P_W'(psum >>> 16) + P_W'(cfg.c));

   assign ql_in = t2_ff * $signed({1'b0, r5_ff[14:0]});
   assign qh_in = t2_ff * $signed({1'b0, r5_ff[R_W-1:15]});

   // p7: k = clamp(t2*r/2^16 + 1 - a - b - c), unity when bypassed
   logic signed [SUM_W-1:0] qsum;
   logic signed [KC_W-1:0]  kc;
   assign qsum = (SUM_W'(qh_ff) <<< 15) + SUM_W'(ql_ff);
   assign kc   = KC_W'(65536) - KC_W'(cfg.a) - KC_W'(cfg.b) - KC_W'(cfg.c);
   assign k_in = side_ff[6].en ? clamp_mid(P_W'(qsum >>> 16) + P_W'(kc)) : K_ONE;

   // p8: d * k
   logic signed [XY_W-1:0] px_in, py_in, px_ff, py_ff;
   assign px_in = side_ff[7].dx * k_ff;
   assign py_in = side_ff[7].dy * k_ff;

   // p9: centre + d*k/2^8, saturated
   logic signed [F_W-1:0]   fx, fy;
   logic signed [OUT_W-1:0] ox_in, oy_in, ox_ff, oy_ff;
   logic                    sat_in, sat_ff;
   assign fx = F_W'($signed({1'b0, side_ff[8].cx, 8'b0})) + F_W'(px_ff >>> 8);
   assign fy = F_W'($signed({1'b0, side_ff[8].cy, 8'b0})) + F_W'(py_ff >>> 8);

   always_comb begin
      logic sx, sy;
      sx = 1'b0;
      sy = 1'b0;
      if (fx > O_HI) begin
         ox_in = OUT_W'(O_HI);
         sx    = 1'b1;
      end else if (fx < O_LO) begin
         ox_in = OUT_W'(O_LO);
         sx    = 1'b1;
      end else begin
         ox_in = OUT_W'(fx);
      end
      if (fy > O_HI) begin
         oy_in = OUT_W'(O_HI);
         sy    = 1'b1;
      end else if (fy < O_LO) begin
         oy_in = OUT_W'(O_LO);
         sy    = 1'b1;
      end else begin
         oy_in = OUT_W'(fy);
      end
      sat_in = sx | sy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[7:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      side_ff[1] <= in_side;
      for (int i = 2; i <= 8; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
      r1_ff  <= rn[ROOT_W+NORM_W-1:16];
      r2_ff  <= r1_ff;
      pa2_ff <= pa_in;
      r3_ff  <= r2_ff;
      t1_ff  <= t1_in;
      r4_ff  <= r3_ff;
      pl_ff  <= pl_in;
      ph_ff  <= ph_in;
      r5_ff  <= r4_ff;
      t2_ff  <= t2_in;
      ql_ff  <= ql_in;
      qh_ff  <= qh_in;
      k_ff   <= k_in;
      px_ff  <= px_in;
      py_ff  <= py_in;
      ox_ff  <= ox_in;
      oy_ff  <= oy_in;
      sat_ff <= sat_in;
   end

   assign out_valid = vld_ff[8];
   assign out_x     = ox_ff;
   assign out_y     = oy_ff;
   assign out_sat   = sat_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/radial_lens_distortion_remap_top.sv
// top level of the radial lens distortion remap pipeline
//
// maps each destination pixel (req_pixel_col, req_pixel_row) to its source
// coordinate under the a,b,c radial model, in signed q13.8 with saturation.
// one item is taken on every clock where start is high; busy never rises,
// and rsp_valid pulses for one cycle with the result once the item has
// passed the pipeline (front stage, sum of squares, 21 square root
// stages of one root bit each, 9 polynomial and output stages). results
// come out in order and the receiver cannot hold them off, so none is
// ever buffered. the user must write registers through the apb-style
// port only while no item is in flight; the block does not enforce this.
`default_nettype none
module radial_lens_distortion_remap_top #(
   parameter int MAX_DIM = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [rld_pkg::PIX_W-1:0]          req_pixel_col,
   input  logic [rld_pkg::PIX_W-1:0]          req_pixel_row,
   output logic                               rsp_valid,
   output logic signed [rld_pkg::OUT_W-1:0]   rsp_source_x,
   output logic signed [rld_pkg::OUT_W-1:0]   rsp_source_y,
   output logic                               rsp_saturated,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [rld_pkg::ADDR_W-1:0]         paddr,
   input  logic [rld_pkg::DATA_W-1:0]         pwdata,
   output logic [rld_pkg::DATA_W-1:0]         prdata,
   output logic                               pready
);
   import rld_pkg::*;

   cfg_type cfg;

   rld_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // the pipeline never stalls, so an item is taken every cycle that start is high
   assign busy = 1'b0;

   // front stage: clamp dimensions, find centre and offset
   logic [DIM_W-1:0] w_eff, h_eff;
   side_type         side_in;
   side_type         side1_ff, side2_ff;
   logic             vld1_ff, vld2_ff;

   always_comb begin
      w_eff = cfg.width;
      h_eff = cfg.height;
      if (int'(cfg.width) > MAX_DIM) begin
         w_eff = DIM_W'(MAX_DIM);
      end
      if (int'(cfg.height) > MAX_DIM) begin
         h_eff = DIM_W'(MAX_DIM);
      end
      side_in.en = cfg.en;
      if (cfg.en) begin
         side_in.cx = w_eff[DIM_W-1:1];
         side_in.cy = h_eff[DIM_W-1:1];
      end else begin
         // identity map: zero centre, unit scale later on
         side_in.cx = '0;
         side_in.cy = '0;
      end
      side_in.dx = $signed({1'b0, req_pixel_col}) - $signed({1'b0, side_in.cx});
      side_in.dy = $signed({1'b0, req_pixel_row}) - $signed({1'b0, side_in.cy});
   end

   // second stage: squared distance from the centre
   logic signed [2*(PIX_W+1)-1:0] sqx, sqy;
   logic [SUMSQ_W-1:0]            sumsq_in, sumsq_ff;
   assign sqx      = side1_ff.dx * side1_ff.dx;
   assign sqy      = side1_ff.dy * side1_ff.dy;
   assign sumsq_in = SUMSQ_W'(sqx) + SUMSQ_W'(sqy);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else begin
         vld1_ff <= start & ~busy;
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      side1_ff <= side_in;
      side2_ff <= side1_ff;
      sumsq_ff <= sumsq_in;
   end

   // radius in q.8: sqrt of the squared distance scaled by 2^16
   logic              vld_r;
   logic [ROOT_W-1:0] root;
   side_type          side_r;

   rld_sqrt u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (vld2_ff),
      .in_radicand ({sumsq_ff, 16'b0}),
      .in_side     (side2_ff),
      .out_valid   (vld_r),
      .out_root    (root),
      .out_side    (side_r)
   );

   // polynomial scale and final coordinates, registered outputs
   rld_poly u_poly (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (vld_r),
      .in_root   (root),
      .in_side   (side_r),
      .out_valid (rsp_valid),
      .out_x     (rsp_source_x),
      .out_y     (rsp_source_y),
      .out_sat   (rsp_saturated)
   );

endmodule
`default_nettype wire
